// ===== rtl/slug_pkg.sv =====
`timescale 1ns / 1ps

package slug_pkg;

    // shuffle table geometry (depth must be a power of two, 2 .. 256)
    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Lehmer generator: s <- 16807 * s mod (2^31 - 1)
    localparam int VAL_W  = 31;
    localparam int MUL_W  = 15;
    localparam int PROD_W = VAL_W + MUL_W;

    localparam logic [MUL_W-1:0] LEH_MUL = MUL_W'(16807);
    localparam logic [VAL_W-1:0] LEH_MOD = {VAL_W{1'b1}};

    // command codes on the cmd field
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    // warm-up steps on a seeding; the last TABLE_DEPTH of them fill the table
    localparam int WARM_STEPS = TABLE_DEPTH + 8;
    localparam int CNT_W      = $clog2(WARM_STEPS);

    // slot = value / (1 + (2^31 - 2) / TABLE_DEPTH) is the top ADDR_W bits
    localparam int SLOT_LSB = VAL_W - ADDR_W;

endpackage

// ===== rtl/slug_ram.sv =====
`timescale 1ns / 1ps

module slug_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/slug_mulmod.sv =====
`timescale 1ns / 1ps

module slug_mulmod (
    input  logic                       i_clk,
    input  logic [slug_pkg::VAL_W-1:0] i_state,
    output logic [slug_pkg::VAL_W-1:0] o_next
);

    logic [slug_pkg::PROD_W-1:0] r_prod;
    logic [slug_pkg::VAL_W:0]    w_sum;

    // product registered every cycle; operand is held by the caller
    always_ff @(posedge i_clk) begin
        r_prod <= slug_pkg::PROD_W'(i_state) * slug_pkg::PROD_W'(slug_pkg::LEH_MUL);
    end

    // Mersenne reduction: hi * 2^31 + lo == hi + lo (mod 2^31 - 1), sum < 2M
    assign w_sum = {1'b0, r_prod[slug_pkg::VAL_W-1:0]}
                 + (slug_pkg::VAL_W+1)'(r_prod[slug_pkg::PROD_W-1:slug_pkg::VAL_W]);

    always_comb begin
        if (w_sum >= {1'b0, slug_pkg::LEH_MOD}) begin
            o_next = slug_pkg::VAL_W'(w_sum - {1'b0, slug_pkg::LEH_MOD});
        end else begin
            o_next = w_sum[slug_pkg::VAL_W-1:0];
        end
    end

endmodule

// ===== rtl/shuffled_lehmer_uniform_generator.sv =====
`timescale 1ns / 1ps
// Draw: result lands in the output register from S_DRAW_WR; no new request is taken until idle.
// Reseed (or first draw after reset): 40 warm-up steps (multiply, then reduce, with a table write
//   in the last TABLE_DEPTH steps) plus the draw through S_DRAW_MUL and S_DRAW_WR.
// Rate is set by the registered multiply/reduce step and the registered table read.
// Reset (synchronous, active low) clears generator state; the table RAM is not cleared,
//   as every seeding rewrites all slots before any is read.
module shuffled_lehmer_uniform_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_cmd,
    input  logic [slug_pkg::VAL_W-1:0] i_seed,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [slug_pkg::VAL_W-1:0] o_out_value
);

    // one-hot sequencer
    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SEED_MUL = 5'b00010,
        S_SEED_RED = 5'b00100,
        S_DRAW_MUL = 5'b01000,
        S_DRAW_WR  = 5'b10000
    } t_fsm;

    t_fsm                        r_fsm, n_fsm;
    logic [slug_pkg::VAL_W-1:0]  r_state, n_state;   // Lehmer state
    logic [slug_pkg::VAL_W-1:0]  r_last, n_last;     // last output, 0 = unseeded
    logic [slug_pkg::CNT_W-1:0]  r_cnt, n_cnt;       // warm-up step counter
    logic                        r_out_valid, n_out_valid;
    logic [slug_pkg::VAL_W-1:0]  r_value, n_value;

    logic                        w_in_xfer;
    logic                        w_reseed;
    logic                        w_need_seed;
    logic [slug_pkg::VAL_W-1:0]  w_next;
    logic [slug_pkg::VAL_W-1:0]  w_rdata;
    logic [slug_pkg::ADDR_W-1:0] w_slot;
    logic                        w_we;
    logic [slug_pkg::ADDR_W-1:0] w_waddr;

    // Input side takes a transfer only when idle and the output register is
    // empty or draining this cycle, so the draw's write stage always finds it free.
    assign o_in_ready  = (r_fsm == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_reseed    = (i_cmd == slug_pkg::CMD_RESEED);
    assign w_need_seed = w_reseed || (r_last == '0);

    // slot picked by the top bits of the last output
    assign w_slot = r_last[slug_pkg::VAL_W-1:slug_pkg::SLOT_LSB];

    // multiply on the current state every cycle; reduced result next cycle
    slug_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_state (r_state),
        .o_next  (w_next)
    );

    // Shuffle table. Read is always addressed at the current slot: the read
    // issued in the transfer (or S_DRAW_MUL) cycle is consumed in S_DRAW_WR,
    // which also writes the new generator value back to the same slot. No
    // read overlaps a pending write to the same entry, so no forwarding.
    assign w_we = ((r_fsm == S_SEED_RED) &&
                   (r_cnt < slug_pkg::CNT_W'(slug_pkg::TABLE_DEPTH))) ||
                  (r_fsm == S_DRAW_WR);
    assign w_waddr = (r_fsm == S_DRAW_WR) ? w_slot : r_cnt[slug_pkg::ADDR_W-1:0];

    slug_ram #(
        .WIDTH (slug_pkg::VAL_W),
        .DEPTH (slug_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_next),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_fsm       = r_fsm;
        n_state     = r_state;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_value     = r_value;

        case (r_fsm)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (w_need_seed) begin
                        // plain draw on an unseeded generator, or a reseed with seed 0, seeds with 1
                        if (w_reseed && (i_seed != '0)) begin
                            n_state = i_seed;
                        end else begin
                            n_state = slug_pkg::VAL_W'(1);
                        end
                        n_cnt = slug_pkg::CNT_W'(slug_pkg::WARM_STEPS - 1);
                        n_fsm = S_SEED_MUL;
                    end else begin
                        n_fsm = S_DRAW_WR;
                    end
                end
            end
            S_SEED_MUL: begin
                n_fsm = S_SEED_RED;
            end
            S_SEED_RED: begin
                n_state = w_next;
                if (r_cnt == '0) begin
                    // slot 0 holds the final warm-up value
                    n_last = w_next;
                    n_fsm  = S_DRAW_MUL;
                end else begin
                    n_cnt = r_cnt - slug_pkg::CNT_W'(1);
                    n_fsm = S_SEED_MUL;
                end
            end
            S_DRAW_MUL: begin
                n_fsm = S_DRAW_WR;
            end
            S_DRAW_WR: begin
                n_state     = w_next;
                n_last      = w_rdata;
                n_value     = w_rdata;
                n_out_valid = 1'b1;
                n_fsm       = S_IDLE;
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_state     <= '0;
            r_last      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_state     <= n_state;
            r_last      <= n_last;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_value <= n_value;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_value;

`ifndef ASSERT_OFF
    // write stage must never find an undelivered result
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_DRAW_WR) |-> !r_out_valid)
        else $error("draw result would overwrite pending output");

    // seeding transfer starts a full warm-up
    a_seed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_need_seed) |=>
            (r_fsm == S_SEED_MUL) &&
            (r_cnt == slug_pkg::CNT_W'(slug_pkg::WARM_STEPS - 1)))
        else $error("reseed did not start warm-up");

    // delivered value is the table word read for the draw
    a_out_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_DRAW_WR) |=> r_out_valid && (o_out_value == $past(w_rdata)))
        else $error("output value does not match table read");

    // after the fill, last output and generator state agree
    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_fsm == S_SEED_RED) && (r_cnt == '0)) |=>
            (r_last == r_state) && (r_fsm == S_DRAW_MUL))
        else $error("fill end left last output out of step");
`endif

endmodule
